>>> sv/oale_pkg.sv
// ============================================================================
// Ordered list engine package
// Shared constants, operation and status codes, and transaction types.
// ============================================================================
package oale_pkg;

    localparam int CAPACITY_DEF = 16;

    // Operation codes carried in the opcode field.
    localparam logic [2:0] OP_APPEND      = 3'd0;
    localparam logic [2:0] OP_INSERT      = 3'd1;
    localparam logic [2:0] OP_REMOVE_LAST = 3'd2;
    localparam logic [2:0] OP_ERASE       = 3'd3;
    localparam logic [2:0] OP_CLEAR       = 3'd4;
    localparam logic [2:0] OP_READ        = 3'd5;
    localparam logic [2:0] OP_WRITE       = 3'd6;

    // Status codes returned with every result.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    typedef enum logic [0:0] {
        CTL_IDLE,
        CTL_RESP
    } ctl_state_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [4:0]         position;
        logic signed [31:0] value;
    } req_item_t;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [4:0]         count;
        logic               is_empty;
        logic [1:0]         status;
    } rsp_item_t;

    typedef struct packed {
        logic exec;
        logic load_out;
    } ctl_cmd_t;

endpackage

>>> sv/ordered_array_list_engine_core.sv
// ============================================================================
// Ordered list engine
// Fixed-capacity ordered list of signed words with append, insert, remove
// last, erase, clear, read and write operations.
// ============================================================================
// Usage:
//   The request channel (req_valid, req_ready, req) carries one operation per
//   transaction: opcode, position and value. The response channel (rsp_valid,
//   rsp_ready, rsp) returns exactly one transaction per request with the word
//   at the addressed index, the new count, an empty flag and a status code.
//   A refused operation leaves the list untouched and reports why.
//   The response becomes valid with the load of the output register. The
//   block works on one request at a time and takes no new one until the last
//   is loaded: the accepting edge updates all element cells and the count in
//   parallel, and a later edge, once the output register is free, loads the
//   addressed cell from the updated list into that register. A new request
//   is taken while a finished response still waits.
//   When the receiver stalls, the response holds in its register and the
//   block stalls after accepting at most one more request.
//   Reset clears the count and the control state; element words are not
//   cleared and are only ever read after they were written.
// ============================================================================
module ordered_array_list_engine_core #(
    parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  oale_pkg::req_item_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output oale_pkg::rsp_item_t rsp
);

    oale_pkg::ctl_cmd_t cmd;

    oale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    oale_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule

>>> sv/oale_datapath.sv
// ============================================================================
// Ordered list engine datapath
// Element cells with neighbor shifting, element count, and result register.
// ============================================================================
module oale_datapath #(
    parameter int CAPACITY = oale_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  oale_pkg::ctl_cmd_t  cmd,
    input  oale_pkg::req_item_t req,
    output oale_pkg::rsp_item_t rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int W  = (CW > 5) ? CW : 5;
    localparam logic [W-1:0] CAP_W = W'(CAPACITY);

    logic signed [31:0] store_reg [CAPACITY];
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic [1:0]         stat_reg;
    logic [1:0]         stat_next;
    logic [W-1:0]       addr_reg;
    logic [W-1:0]       addr_next;
    logic               has_addr_reg;
    logic               has_addr_next;
    oale_pkg::rsp_item_t rsp_reg;
    oale_pkg::rsp_item_t rsp_next;

    logic [W-1:0] pos_w;
    logic [W-1:0] cnt_w;
    logic         do_app;
    logic         do_ins;
    logic         do_ers;
    logic         do_wr;

    logic               cell_we [CAPACITY];
    logic signed [31:0] cell_d  [CAPACITY];

    assign pos_w = W'(req.position);
    assign cnt_w = W'(cnt_reg);

    // Decode the operation against the current count.
    always_comb
    begin
        stat_next     = oale_pkg::ST_OK;
        cnt_next      = cnt_reg;
        addr_next     = pos_w;
        has_addr_next = 1'b0;
        do_app        = 1'b0;
        do_ins        = 1'b0;
        do_ers        = 1'b0;
        do_wr         = 1'b0;
        unique case (req.opcode)
            oale_pkg::OP_APPEND:
            begin
                has_addr_next = 1'b1;
                if (cnt_w == CAP_W)
                begin
                    stat_next = oale_pkg::ST_FULL;
                    addr_next = cnt_w - W'(1);
                end
                else
                begin
                    do_app    = 1'b1;
                    cnt_next  = cnt_reg + CW'(1);
                    addr_next = cnt_w;
                end
            end
            oale_pkg::OP_INSERT:
            begin
                has_addr_next = 1'b1;
                if (pos_w > cnt_w)
                begin
                    stat_next = oale_pkg::ST_RANGE;
                end
                else if (cnt_w == CAP_W)
                begin
                    stat_next = oale_pkg::ST_FULL;
                end
                else
                begin
                    do_ins   = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            oale_pkg::OP_REMOVE_LAST:
            begin
                if (cnt_w == '0)
                begin
                    stat_next = oale_pkg::ST_EMPTY;
                end
                else
                begin
                    cnt_next      = cnt_reg - CW'(1);
                    has_addr_next = (cnt_w > W'(1));
                    addr_next     = cnt_w - W'(2);
                end
            end
            oale_pkg::OP_ERASE:
            begin
                has_addr_next = 1'b1;
                if (cnt_w == '0)
                begin
                    stat_next = oale_pkg::ST_EMPTY;
                end
                else if (pos_w >= cnt_w)
                begin
                    stat_next = oale_pkg::ST_RANGE;
                end
                else
                begin
                    do_ers   = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            oale_pkg::OP_CLEAR:
            begin
                cnt_next = '0;
            end
            oale_pkg::OP_READ:
            begin
                has_addr_next = 1'b1;
                if (pos_w >= cnt_w)
                begin
                    stat_next = oale_pkg::ST_RANGE;
                end
            end
            oale_pkg::OP_WRITE:
            begin
                has_addr_next = 1'b1;
                if (pos_w >= cnt_w)
                begin
                    stat_next = oale_pkg::ST_RANGE;
                end
                else
                begin
                    do_wr = 1'b1;
                end
            end
            default:
            begin
                stat_next = oale_pkg::ST_OK;
            end
        endcase
    end

    // Each cell takes the new word, its lower neighbor (insert) or its upper
    // neighbor (erase), all in the same cycle.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [W-1:0] IDX = W'(i);
        logic               from_lo;
        logic               from_hi;
        logic signed [31:0] lo_word;
        logic signed [31:0] hi_word;

        if (i > 0)
        begin : g_lo
            assign from_lo = do_ins && (IDX > pos_w) && (IDX <= cnt_w);
            assign lo_word = store_reg[i-1];
        end
        else
        begin : g_lo_none
            assign from_lo = 1'b0;
            assign lo_word = '0;
        end

        if (i < CAPACITY - 1)
        begin : g_hi
            assign from_hi = do_ers && (IDX >= pos_w) && ((IDX + W'(1)) < cnt_w);
            assign hi_word = store_reg[i+1];
        end
        else
        begin : g_hi_none
            assign from_hi = 1'b0;
            assign hi_word = '0;
        end

        always_comb
        begin
            cell_we[i] = 1'b1;
            if (do_app && (cnt_w == IDX))
            begin
                cell_d[i] = req.value;
            end
            else if ((do_ins || do_wr) && (pos_w == IDX))
            begin
                cell_d[i] = req.value;
            end
            else if (from_lo)
            begin
                cell_d[i] = lo_word;
            end
            else if (from_hi)
            begin
                cell_d[i] = hi_word;
            end
            else
            begin
                cell_we[i] = 1'b0;
                cell_d[i]  = store_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            for (int k = 0; k < CAPACITY; k++)
            begin
                if (cell_we[k])
                begin
                    store_reg[k] <= cell_d[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.exec)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            stat_reg     <= stat_next;
            addr_reg     <= addr_next;
            has_addr_reg <= has_addr_next;
        end
    end

    // The addressed word is read from the updated list held in the element cells.
    always_comb
    begin
        rsp_next.read_value = '0;
        if (has_addr_reg && (addr_reg < cnt_w))
        begin
            rsp_next.read_value = store_reg[addr_reg[IW-1:0]];
        end
        rsp_next.count    = 5'(cnt_reg);
        rsp_next.is_empty = (cnt_reg == '0);
        rsp_next.status   = stat_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_w <= CAP_W)
        else $error("element count exceeds capacity");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (req.opcode == oale_pkg::OP_CLEAR) |=> (cnt_reg == '0))
        else $error("clear did not empty the list");

    a_refused_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && (stat_next != oale_pkg::ST_OK) |=> $stable(cnt_reg))
        else $error("refused operation changed the count");

endmodule

>>> sv/oale_ctrl.sv
// ============================================================================
// Ordered list engine controller
// Sequences execute and result load, and owns the handshake flags.
// ============================================================================
module oale_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output oale_pkg::ctl_cmd_t cmd
);

    oale_pkg::ctl_state_t state_reg;
    oale_pkg::ctl_state_t state_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    logic                 out_free;

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            oale_pkg::CTL_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = oale_pkg::CTL_RESP;
                end
            end
            oale_pkg::CTL_RESP:
            begin
                if (out_free)
                begin
                    state_next = oale_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = oale_pkg::CTL_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready    = 1'b0;
        cmd.exec     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            oale_pkg::CTL_IDLE:
            begin
                req_ready = 1'b1;
                cmd.exec  = req_valid;
            end
            oale_pkg::CTL_RESP:
            begin
                cmd.load_out = out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= oale_pkg::CTL_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    a_load_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid_reg || rsp_ready))
        else $error("result register overwritten before it was taken");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready && cmd.load_out == out_free)
        else $error("second transaction accepted while one is executing");

    a_valid_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(cmd.load_out))
        else $error("result valid raised without a load");

endmodule
